// ----- hw/rtl/gms_pkg.sv -----
// Shared types and constants for the grouped mean / standard deviation block.
// Used by gms_datapath, gms_ctrl and grouped_mean_stddev_top. No dependencies.
package gms_pkg;

    localparam int IN_TDATA_W  = 56;   // a, b, c, is_male padded to bytes
    localparam int IN_TUSER_W  = 1;    // opcode
    localparam int OUT_TDATA_W = 64;   // count, mean, std, flags padded to bytes
    localparam int OUT_TUSER_W = 4;    // group_sel, measure_sel
    localparam int FIELD_W     = 16;   // input measurement field width
    localparam int CNT_OUT_W   = 7;
    localparam int Q_OUT_W     = 24;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [1:0] GRP_ALL    = 2'd0;
    localparam logic [1:0] GRP_MALE   = 2'd1;
    localparam logic [1:0] GRP_FEMALE = 2'd2;
    localparam logic [1:0] MEAS_LAST  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P1_GO,
        S_P1,
        S_DIV1_GO,
        S_DIV1,
        S_P2_GO,
        S_P2,
        S_DIV2_GO,
        S_DIV2,
        S_SQRT_GO,
        S_SQRT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic add;        // store one record
        logic rep_start;  // report begins: select first group/measure
        logic walk_go;    // start a walk over the store
        logic pass2;      // walk accumulates squared deviations
        logic div_go;     // start the shared divider
        logic div_var;    // divide sq sum by n-1 (else sum*256 by n)
        logic sqrt_go;    // start the square root on the quotient
        logic take_mean;
        logic take_sd;
        logic load_out;   // load the result register
        logic next_sel;
        logic clear;      // empty the store after the report
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic unit_done;
        logic n_ge1;
        logic n_ge2;
        logic out_free;
        logic last_sel;
    } t_sts;

endpackage

// ----- hw/rtl/grouped_mean_stddev_top.sv -----
// Add request: stored (dropped with the overflow flag set when full), one per cycle
// while no report is running. Report request: nine results, each from a first walk
// over the store, a 64-step divide, a second walk, a 64-step divide and a 32-step root;
// groups under two records skip the second half. Results leave through a register.
// Reset (synchronous, active low) empties the store and clears the overflow flag.
// Depends on gms_pkg, gms_ctrl, gms_datapath, gms_ram.
module grouped_mean_stddev_top
    import gms_pkg::*;
#(
    parameter int MAX_RECORDS  = 64,
    parameter int MEASURE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] measure_a, [31:16] measure_b, [47:32] measure_c, [48] is_male
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [6:0] group_count, [30:7] mean_q8, [54:31] std_q8, [55] mean_valid,
    // [56] std_valid, [57] overflowed
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] group_sel, [3:2] measure_sel
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);
    t_cmd cmd;
    t_sts sts;

    // controller takes requests only while idle; a result may still be waiting
    gms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser[0]),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gms_datapath #(
        .MAX_RECORDS  (MAX_RECORDS),
        .MEASURE_BITS (MEASURE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );
endmodule

// ----- hw/rtl/gms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gms_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/gms_datapath.sv -----
// Datapath: record store, walk accumulators, shared divider / square root
// unit and the result register. Depends on gms_pkg and gms_ram.
module gms_datapath
    import gms_pkg::*;
#(
    parameter int MAX_RECORDS  = 64,
    parameter int MEASURE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [OUT_TUSER_W-1:0] o_m_tuser,
    output logic                   o_m_tlast
);
    localparam int MB   = MEASURE_BITS;
    localparam int AW   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNTW = $clog2(MAX_RECORDS + 1);
    localparam int MW   = MB + 8;
    localparam int SW   = MB + CNTW;
    localparam int RW   = 3 * MB + 1;

    // store
    logic [CNTW-1:0] r_count;
    logic            r_ovf;
    logic            full;
    logic [RW-1:0]   wdata, rdata;
    logic [MB-1:0]   fa, fb, fc;

    // walk
    logic [CNTW-1:0] r_idx;
    logic            r_walk, r_rd_vld, r_pass2, r_p_vld;
    logic [1:0]      r_g, r_m;
    logic [MB-1:0]   x;
    logic            in_grp;
    logic [MW-1:0]   x8, d;
    logic [2*MW-1:0] d_sq;
    logic [CNTW-1:0] r_n;
    logic [SW-1:0]   r_sum;
    logic [63:0]     r_p, r_sq;
    logic [64:0]     sq_add;
    logic [MW-1:0]   r_mean;
    logic [31:0]     r_sd;

    // divider / sqrt unit
    logic            r_busy, r_is_sqrt;
    logic [5:0]      r_step;
    logic [63:0]     r_dq;
    logic [CNTW-1:0] r_drem, r_dvs;
    logic [CNTW:0]   drem_sh;
    logic [34:0]     r_rem, rem_sh, trial;
    logic [31:0]     r_root;

    // result register
    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_tdata;
    logic [OUT_TUSER_W-1:0] r_tuser;
    logic                   r_tlast;
    logic [CNT_OUT_W-1:0]   cnt_sat;
    logic [Q_OUT_W-1:0]     mean_sat, sd_sat;
    logic [CNTW+CNT_OUT_W-1:0] n_ext;
    logic [MW+Q_OUT_W-1:0]  mean_ext;

    assign fa = MB'({24'd0, i_s_tdata[15:0]});
    assign fb = MB'({24'd0, i_s_tdata[31:16]});
    assign fc = MB'({24'd0, i_s_tdata[47:32]});
    assign wdata = {i_s_tdata[48], fc, fb, fa};
    assign full  = (r_count >= CNTW'(MAX_RECORDS));

    gms_ram #(.W(RW), .D(MAX_RECORDS)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add && !full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.add) begin
            if (full) r_ovf <= 1'b1;
            else      r_count <= r_count + CNTW'(1);
        end
    end

    // group / measure selection of the record being read
    always_comb begin
        case (r_m)
            2'd0:    x = rdata[MB-1:0];
            2'd1:    x = rdata[2*MB-1:MB];
            default: x = rdata[3*MB-1:2*MB];
        endcase
        case (r_g)
            GRP_ALL:  in_grp = 1'b1;
            GRP_MALE: in_grp = rdata[RW-1];
            default:  in_grp = !rdata[RW-1];
        endcase
    end

    assign x8 = {x, 8'd0};
    assign d  = (x8 >= r_mean) ? (x8 - r_mean) : (r_mean - x8);
    assign d_sq = d * d;
    assign sq_add = {1'b0, r_sq} + {1'b0, r_p};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_p_vld  <= 1'b0;
        end else begin
            r_rd_vld <= r_walk;
            r_p_vld  <= r_rd_vld && r_pass2 && in_grp;
            if (i_cmd.walk_go) begin
                r_walk <= (r_count != '0);
            end else if (r_walk && (r_idx + CNTW'(1) == r_count)) begin
                r_walk <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_go) begin
            r_idx   <= '0;
            r_pass2 <= i_cmd.pass2;
        end else if (r_walk) begin
            r_idx <= r_idx + CNTW'(1);
        end
        r_p <= 64'(d_sq);
        if (i_cmd.walk_go && !i_cmd.pass2) begin
            r_n    <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_mean <= '0;
            r_sd   <= '0;
        end else begin
            if (r_rd_vld && !r_pass2 && in_grp) begin
                r_n   <= r_n + CNTW'(1);
                r_sum <= r_sum + SW'(x);
            end
            if (r_p_vld) r_sq <= sq_add[64] ? '1 : sq_add[63:0];
            if (i_cmd.take_mean) r_mean <= r_dq[MW-1:0];
            if (i_cmd.take_sd)   r_sd   <= r_root;
        end
    end

    // shared unit: restoring divide (64 steps) or digit-by-digit root (32 steps)
    assign drem_sh = {r_drem, r_dq[63]};
    assign rem_sh  = {r_rem[32:0], r_dq[63:62]};
    assign trial   = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.div_go || i_cmd.sqrt_go) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_step == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_is_sqrt <= 1'b0;
            r_step    <= 6'd63;
            r_drem    <= '0;
            r_dq      <= i_cmd.div_var ? r_sq : 64'({r_sum, 8'd0});
            r_dvs     <= i_cmd.div_var ? (r_n - CNTW'(1)) : r_n;
        end else if (i_cmd.sqrt_go) begin
            r_is_sqrt <= 1'b1;
            r_step    <= 6'd31;
            r_rem     <= '0;
            r_root    <= '0;
        end else if (r_busy) begin
            r_step <= r_step - 6'd1;
            if (r_is_sqrt) begin
                r_dq <= {r_dq[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end else if (drem_sh >= {1'b0, r_dvs}) begin
                r_drem <= CNTW'(drem_sh - {1'b0, r_dvs});
                r_dq   <= {r_dq[62:0], 1'b1};
            end else begin
                r_drem <= drem_sh[CNTW-1:0];
                r_dq   <= {r_dq[62:0], 1'b0};
            end
        end
    end

    // group / measure sequencing
    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_start) begin
            r_g <= GRP_ALL;
            r_m <= 2'd0;
        end else if (i_cmd.next_sel) begin
            if (r_m == MEAS_LAST) begin
                r_m <= 2'd0;
                r_g <= r_g + 2'd1;
            end else begin
                r_m <= r_m + 2'd1;
            end
        end
    end

    // saturation to the result field widths
    assign n_ext    = {{CNT_OUT_W{1'b0}}, r_n};
    assign cnt_sat  = (n_ext > (CNTW+CNT_OUT_W)'(127)) ? '1 : n_ext[CNT_OUT_W-1:0];
    assign mean_ext = {{Q_OUT_W{1'b0}}, r_mean};
    assign mean_sat = (mean_ext > (MW+Q_OUT_W)'(24'hFFFFFF)) ? '1 : mean_ext[Q_OUT_W-1:0];
    assign sd_sat   = (r_sd[31:24] != 8'd0) ? '1 : r_sd[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_tdata <= {6'd0, r_ovf, (r_n > CNTW'(1)), (r_n != '0),
                        sd_sat, mean_sat, cnt_sat};
            r_tuser <= {r_m, r_g};
            r_tlast <= (r_g == GRP_FEMALE) && (r_m == MEAS_LAST);
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;
    assign o_m_tlast  = r_tlast;

    assign o_sts.walk_done = !r_walk && !r_rd_vld && !r_p_vld;
    assign o_sts.unit_done = !r_busy;
    assign o_sts.n_ge1     = (r_n != '0);
    assign o_sts.n_ge2     = (r_n > CNTW'(1));
    assign o_sts.out_free  = !r_out_vld || i_m_tready;
    assign o_sts.last_sel  = (r_g == GRP_FEMALE) && (r_m == MEAS_LAST);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_RECORDS))
        else $error("record count beyond capacity");
    a_unit_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_go || i_cmd.sqrt_go) |-> !r_busy)
        else $error("unit started while busy");
    a_walk_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_go |-> (!r_walk && !r_rd_vld))
        else $error("walk started while walking");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_vld || i_m_tready))
        else $error("result register overwritten");
endmodule

// ----- hw/rtl/gms_ctrl.sv -----
// Controller FSM: sequences adds, the two walks, divide, root and emission.
// Depends on gms_pkg.
module gms_ctrl
    import gms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_opcode,
    output logic  o_s_tready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   acc;

    assign acc = i_s_tvalid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (acc && i_opcode == OP_REPORT) n_state = S_P1_GO;
            S_P1_GO:   n_state = S_P1;
            S_P1:      if (i_sts.walk_done) n_state = i_sts.n_ge1 ? S_DIV1_GO : S_EMIT;
            S_DIV1_GO: n_state = S_DIV1;
            S_DIV1:    if (i_sts.unit_done) n_state = i_sts.n_ge2 ? S_P2_GO : S_EMIT;
            S_P2_GO:   n_state = S_P2;
            S_P2:      if (i_sts.walk_done) n_state = S_DIV2_GO;
            S_DIV2_GO: n_state = S_DIV2;
            S_DIV2:    if (i_sts.unit_done) n_state = S_SQRT_GO;
            S_SQRT_GO: n_state = S_SQRT;
            S_SQRT:    if (i_sts.unit_done) n_state = S_EMIT;
            S_EMIT:    if (i_sts.out_free) n_state = i_sts.last_sel ? S_IDLE : S_P1_GO;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.add       = acc && (i_opcode == OP_ADD);
                o_cmd.rep_start = acc && (i_opcode == OP_REPORT);
            end
            S_P1_GO:   o_cmd.walk_go = 1'b1;
            S_DIV1_GO: o_cmd.div_go = 1'b1;
            S_DIV1:    o_cmd.take_mean = i_sts.unit_done;
            S_P2_GO: begin
                o_cmd.walk_go = 1'b1;
                o_cmd.pass2   = 1'b1;
            end
            S_DIV2_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_var = 1'b1;
            end
            S_SQRT_GO: o_cmd.sqrt_go = 1'b1;
            S_SQRT:    o_cmd.take_sd = i_sts.unit_done;
            S_EMIT: begin
                o_cmd.load_out = i_sts.out_free;
                o_cmd.next_sel = i_sts.out_free && !i_sts.last_sel;
                o_cmd.clear    = i_sts.out_free && i_sts.last_sel;
            end
            default: ;
        endcase
    end
endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for grouped_mean_stddev_top: streams add and report requests,
// predicts the nine per-group statistics of each report and checks them in order.
// Depends on gms_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
    import gms_pkg::*;

    localparam int NREC = 64;

    typedef struct packed {
        logic [1:0]  grp;
        logic [1:0]  meas;
        logic [6:0]  cnt;
        logic [23:0] mean;
        logic [23:0] sd;
        logic        mv;
        logic        sv;
        logic        ovf;
        logic        lst;
    } stat_t;

    typedef struct packed {
        logic        op;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic        male;
        logic        wait_idle;   // hold this request until no result is pending
    } req_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    grouped_mean_stddev_top dut (.*);

    always #5 i_clk = ~i_clk;

    req_t  pending_reqs[$];
    stat_t expected_stats[$];
    int    errors = 0;
    bit    calm = 1'b0;       // no idling in the closing part
    bit    stim_done = 1'b0;

    // predictor state
    logic [15:0] st_m[NREC][3];
    logic        st_male[NREC];
    int          st_cnt = 0;
    bit          st_ovf = 1'b0;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic bit member(int i, int g);
        return (g == 0) || (g == 1 && st_male[i]) || (g == 2 && !st_male[i]);
    endfunction

    task automatic predict_request(req_t r);
        stat_t s;
        logic [63:0] n, sum, mean, sq, x, d, p, sd;
        if (r.op == OP_ADD) begin
            if (st_cnt < NREC) begin
                st_m[st_cnt][0] = r.a;
                st_m[st_cnt][1] = r.b;
                st_m[st_cnt][2] = r.c;
                st_male[st_cnt] = r.male;
                st_cnt++;
            end else begin
                st_ovf = 1'b1;
            end
            return;
        end
        for (int g = 0; g < 3; g++) begin
            for (int m = 0; m < 3; m++) begin
                n = 0; sum = 0; mean = 0; sq = 0; sd = 0;
                for (int i = 0; i < st_cnt; i++)
                    if (member(i, g)) begin
                        n++;
                        sum += st_m[i][m];
                    end
                if (n > 0) mean = (sum << 8) / n;
                if (n > 1) begin
                    for (int i = 0; i < st_cnt; i++)
                        if (member(i, g)) begin
                            x = {40'd0, st_m[i][m], 8'd0};
                            d = (x >= mean) ? x - mean : mean - x;
                            p = d * d;
                            sq = (sq > ~64'd0 - p) ? ~64'd0 : sq + p;
                        end
                    sd = isqrt(sq / (n - 1));
                end
                s.grp  = 2'(g);
                s.meas = 2'(m);
                s.cnt  = (n > 127) ? 7'd127 : n[6:0];
                s.mean = (mean > 64'hFFFFFF) ? 24'hFFFFFF : mean[23:0];
                s.sd   = (sd > 64'hFFFFFF) ? 24'hFFFFFF : sd[23:0];
                s.mv   = (n >= 1);
                s.sv   = (n >= 2);
                s.ovf  = st_ovf;
                s.lst  = (2'(g) == GRP_FEMALE && 2'(m) == MEAS_LAST);
                expected_stats.push_back(s);
            end
        end
        st_cnt = 0;
        st_ovf = 1'b0;
    endtask

    function automatic req_t make_add(bit wide);
        req_t r;
        r.op = OP_ADD;
        r.a = wide ? 16'($urandom) : 16'($urandom_range(0, 300));
        r.b = wide ? 16'($urandom) : 16'($urandom_range(1000, 2000));
        r.c = wide ? 16'($urandom) : 16'($urandom_range(400, 1200));
        r.male = $urandom_range(0, 1);
        r.wait_idle = 1'b0;
        return r;
    endfunction

    function automatic req_t make_report(bit hold);
        req_t r;
        r = '0;
        r.op = OP_REPORT;
        r.a = 16'($urandom);
        r.b = 16'($urandom);
        r.c = 16'($urandom);
        r.male = $urandom_range(0, 1);
        r.wait_idle = hold;
        return r;
    endfunction

    function automatic req_t make_fixed(logic [15:0] v, logic male);
        req_t r;
        r = '0;
        r.op = OP_ADD;
        r.a = v; r.b = v; r.c = v;
        r.male = male;
        return r;
    endfunction

    // Sender: requests are predicted at acceptance, so order matches the DUT.
    int  tx_gap = 0;
    bit  tx_hold;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(pending_reqs.pop_front());
                if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 11);
            end
            tx_hold = (tx_gap > 0) || pending_reqs.size() == 0 ||
                      (pending_reqs[0].wait_idle && expected_stats.size() != 0);
            if (tx_gap > 0) tx_gap--;
            if (tx_hold) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, pending_reqs[0].male, pending_reqs[0].c,
                                  pending_reqs[0].b, pending_reqs[0].a};
                s_axis_tuser  <= pending_reqs[0].op;
            end
        end
    end

    // Receiver with random stall bursts.
    int rx_gap = 0;
    stat_t got, want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser[1:0], m_axis_tuser[3:2], m_axis_tdata[6:0],
                        m_axis_tdata[30:7], m_axis_tdata[54:31], m_axis_tdata[55],
                        m_axis_tdata[56], m_axis_tdata[57], m_axis_tlast};
                if (expected_stats.size() == 0) begin
                    $error("unexpected result: tuser=%h tdata=%h", m_axis_tuser, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_stats.pop_front();
                    if (got.grp != want.grp) begin
                        $error("group_sel exp %0d got %0d", want.grp, got.grp); errors++;
                    end
                    if (got.meas != want.meas) begin
                        $error("measure_sel exp %0d got %0d", want.meas, got.meas); errors++;
                    end
                    if (got.cnt != want.cnt) begin
                        $error("group_count exp %0d got %0d", want.cnt, got.cnt); errors++;
                    end
                    if (got.mean != want.mean) begin
                        $error("mean_q8 exp %0d got %0d", want.mean, got.mean); errors++;
                    end
                    if (got.sd != want.sd) begin
                        $error("std_q8 exp %0d got %0d", want.sd, got.sd); errors++;
                    end
                    if (got.mv != want.mv) begin
                        $error("mean_valid exp %0d got %0d", want.mv, got.mv); errors++;
                    end
                    if (got.sv != want.sv) begin
                        $error("std_valid exp %0d got %0d", want.sv, got.sv); errors++;
                    end
                    if (got.ovf != want.ovf) begin
                        $error("overflowed exp %0d got %0d", want.ovf, got.ovf); errors++;
                    end
                    if (got.lst != want.lst) begin
                        $error("last exp %0d got %0d", want.lst, got.lst); errors++;
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                rx_gap = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        int nrand;
        // report on empty store, then single-record groups
        pending_reqs.push_back(make_report(1'b0));
        pending_reqs.push_back(make_fixed(16'hFFFF, 1'b1));
        pending_reqs.push_back(make_report(1'b0));
        // max and min values, both groups
        pending_reqs.push_back(make_fixed(16'hFFFF, 1'b1));
        pending_reqs.push_back(make_fixed(16'h0000, 1'b1));
        pending_reqs.push_back(make_fixed(16'hFFFF, 1'b0));
        pending_reqs.push_back(make_fixed(16'h0000, 1'b0));
        pending_reqs.push_back(make_fixed(16'h5555, 1'b0));
        pending_reqs.push_back(make_fixed(16'hAAAA, 1'b1));
        pending_reqs.push_back(make_report(1'b1));
        // fill the store past capacity: dropped adds set the overflow flag
        for (int i = 0; i < 66; i++) pending_reqs.push_back(make_add(i[0]));
        pending_reqs.push_back(make_report(1'b0));
        // overflow must be cleared by the report
        pending_reqs.push_back(make_add(1'b1));
        pending_reqs.push_back(make_report(1'b1));
        // random frames of small runs of records
        nrand = 0;
        while (nrand < 50) begin
            int len;
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) pending_reqs.push_back(make_add($urandom_range(0, 1)));
            pending_reqs.push_back(make_report($urandom_range(0, 7) == 0));
            nrand += len + 1;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() < 20);
        calm = 1'b1;
        wait (pending_reqs.size() == 0 && !s_axis_tvalid);
        wait (expected_stats.size() == 0);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_stats.size() == 0) begin
            $display("grouped_mean_stddev_top test passed");
        end else begin
            $display("grouped_mean_stddev_top test failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("grouped_mean_stddev_top test failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/gms_pkg.sv
hw/rtl/gms_ram.sv
hw/rtl/gms_datapath.sv
hw/rtl/gms_ctrl.sv
hw/rtl/grouped_mean_stddev_top.sv
dv/tb_top.sv
